// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the pruning block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define BNCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define BNCP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BNCP_ASSERT(lbl, clk, rst_n, prop, msg)
`define BNCP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/bncp_pkg.sv =====
// Types, constants and register codes of the neighbour count pruning block.
package bncp_pkg;

    localparam int ROW_W         = 64;
    localparam int WIDTH_W       = 7;
    localparam int MIN_W         = 4;
    localparam int CFG_DATA_W    = 7;
    localparam int CFG_IDX_W     = 2;
    localparam int NEIGHBOURS    = 8;
    localparam int PASSES_DEF    = 2;
    localparam int MAX_WIDTH_DEF = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NEIGHBOURS = 2'd1;

    localparam logic [WIDTH_W-1:0] ROW_WIDTH_RST = 7'd64;
    localparam logic [MIN_W-1:0]   MIN_NB_RST    = 4'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row_bits;
        logic             last_row;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0] pruned_row;
        logic             frame_end;
    } out_item_t;

    typedef struct packed {
        logic [MIN_W-1:0] min_neighbours;
    } pass_ctrl_t;

endpackage

// ===== rtl/core/bncp_fifo.sv =====
// Small register queue with count-based full and empty flags.
`include "assert_macros.svh"

module bncp_fifo #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `BNCP_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "queue count overflow")

endmodule

// ===== rtl/core/bncp_front.sv =====
// Front end: configuration registers, width mask, input masking into the queue.
module bncp_front #(
    parameter int MAX_WIDTH = bncp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bncp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bncp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            push,
    input  bncp_pkg::in_item_t              item,
    input  logic                            q_full,
    output logic                            q_wr,
    output logic [MAX_WIDTH:0]              q_data,
    output bncp_pkg::pass_ctrl_t            ctrl,
    output logic [MAX_WIDTH-1:0]            mask
);
    import bncp_pkg::*;

    logic [WIDTH_W-1:0] row_width_reg, row_width_next;
    logic [MIN_W-1:0]   min_nb_reg, min_nb_next;

    always_comb
    begin
        row_width_next = row_width_reg;
        min_nb_next    = min_nb_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROW_WIDTH:      row_width_next = cfg_data[WIDTH_W-1:0];
                CFG_MIN_NEIGHBOURS: min_nb_next    = cfg_data[MIN_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RST;
            min_nb_reg    <= MIN_NB_RST;
        end
        else
        begin
            row_width_reg <= row_width_next;
            min_nb_reg    <= min_nb_next;
        end
    end

    // column x is live when x < row_width; widths past MAX_WIDTH clamp naturally
    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            mask[x] = (WIDTH_W'(x) < row_width_reg);
        end
    end

    assign ctrl.min_neighbours = min_nb_reg;
    assign q_wr   = push && !q_full;
    assign q_data = {item.last_row, item.row_bits[MAX_WIDTH-1:0] & mask};

endmodule

// ===== rtl/core/bncp_stage.sv =====
// One pruning pass: two-row window, one 3x3 neighbour count per column, output register.
`include "assert_macros.svh"

module bncp_stage #(
    parameter int MAX_WIDTH = bncp_pkg::MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bncp_pkg::pass_ctrl_t ctrl,
    input  logic [MAX_WIDTH-1:0] mask,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MAX_WIDTH-1:0] in_row,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MAX_WIDTH-1:0] out_row,
    output logic                 out_last
);
    import bncp_pkg::*;

    localparam int CNT_W = $clog2(NEIGHBOURS + 1);

    logic [MAX_WIDTH-1:0] older_reg, older_next;
    logic [MAX_WIDTH-1:0] newer_reg, newer_next;
    logic [1:0]           fill_reg, fill_next;
    logic                 pend_reg, pend_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MAX_WIDTH-1:0] out_row_reg, out_row_next;
    logic                 out_last_reg, out_last_next;

    logic                 load_ok, in_fire;
    logic [MAX_WIDTH-1:0] above, cur, below, pruned;
    logic [MAX_WIDTH+1:0] a_p, c_p, b_p;

    function automatic logic [CNT_W-1:0] count8(input logic [NEIGHBOURS-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NEIGHBOURS; i++)
        begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

    assign load_ok  = !out_valid_reg || out_ready;
    assign in_ready = load_ok && !pend_reg;
    assign in_fire  = in_valid && in_ready;

    // window select: pending flush, first row of frame, or steady feed
    always_comb
    begin
        if (pend_reg)
        begin
            above = older_reg;
            cur   = newer_reg;
            below = '0;
        end
        else if (fill_reg == 2'd0)
        begin
            above = '0;
            cur   = in_row;
            below = '0;
        end
        else
        begin
            above = (fill_reg == 2'd2) ? older_reg : '0;
            cur   = newer_reg;
            below = in_row;
        end
    end

    // pad by a clear column on each side; index x+1 is column x
    assign a_p = {1'b0, above & mask, 1'b0};
    assign c_p = {1'b0, cur & mask, 1'b0};
    assign b_p = {1'b0, below & mask, 1'b0};

    always_comb
    begin
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            pruned[x] = c_p[x+1] &&
                (count8({a_p[x], a_p[x+1], a_p[x+2], c_p[x], c_p[x+2],
                         b_p[x], b_p[x+1], b_p[x+2]}) >= ctrl.min_neighbours);
        end
    end

    always_comb
    begin
        older_next     = older_reg;
        newer_next     = newer_reg;
        fill_next      = fill_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_last_next  = out_last_reg;
        if (pend_reg)
        begin
            if (load_ok)
            begin
                out_valid_next = 1'b1;
                out_row_next   = pruned;
                out_last_next  = 1'b1;
                pend_next      = 1'b0;
                fill_next      = 2'd0;
            end
        end
        else if (in_fire)
        begin
            if (fill_reg == 2'd0)
            begin
                if (in_last)
                begin
                    // single-row frame: flush straight out
                    out_valid_next = 1'b1;
                    out_row_next   = pruned;
                    out_last_next  = 1'b1;
                end
                else
                begin
                    newer_next = in_row;
                    fill_next  = 2'd1;
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                out_row_next   = pruned;
                out_last_next  = 1'b0;
                older_next     = newer_reg;
                newer_next     = in_row;
                fill_next      = 2'd2;
                pend_next      = in_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 2'd0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        older_reg    <= older_next;
        newer_reg    <= newer_next;
        out_row_reg  <= out_row_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_last  = out_last_reg;

    `BNCP_ASSERT(a_pend_full, clk, rst_n, pend_reg |-> (fill_reg == 2'd2), "flush pending without full window")
    `BNCP_ASSERT(a_single_flush, clk, rst_n, (in_fire && in_last && fill_reg == 2'd0) |=> (out_valid_reg && out_last_reg && fill_reg == 2'd0), "single-row frame not flushed")
    `BNCP_ASSERT_NEVER(a_end_empty, clk, rst_n, out_valid_reg && out_last_reg && fill_reg != 2'd0, "window not empty at frame end")

endmodule

// ===== rtl/core/bncp_back.sv =====
// Back end: chain of pruning passes, each with its own output register.
module bncp_back #(
    parameter int PASSES    = bncp_pkg::PASSES_DEF,
    parameter int MAX_WIDTH = bncp_pkg::MAX_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bncp_pkg::pass_ctrl_t ctrl,
    input  logic [MAX_WIDTH-1:0] mask,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [MAX_WIDTH-1:0] in_row,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [MAX_WIDTH-1:0] out_row,
    output logic                 out_last
);
    logic [PASSES:0]      lnk_valid, lnk_ready, lnk_last;
    logic [MAX_WIDTH-1:0] lnk_row [PASSES+1];

    assign lnk_valid[0] = in_valid;
    assign lnk_row[0]   = in_row;
    assign lnk_last[0]  = in_last;
    assign in_ready     = lnk_ready[0];

    for (genvar s = 0; s < PASSES; s++)
    begin : g_pass
        bncp_stage #(
            .MAX_WIDTH(MAX_WIDTH)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .mask     (mask),
            .in_valid (lnk_valid[s]),
            .in_ready (lnk_ready[s]),
            .in_row   (lnk_row[s]),
            .in_last  (lnk_last[s]),
            .out_valid(lnk_valid[s+1]),
            .out_ready(lnk_ready[s+1]),
            .out_row  (lnk_row[s+1]),
            .out_last (lnk_last[s+1])
        );
    end

    assign lnk_ready[PASSES] = out_ready;
    assign out_valid         = lnk_valid[PASSES];
    assign out_row           = lnk_row[PASSES];
    assign out_last          = lnk_last[PASSES];

endmodule

// ===== rtl/core/binary_neighbour_count_prune.sv =====
// Top level of the binary 3x3 neighbour count pruning block.
//
// Streams a binary mask frame one row per request and clears every set pixel
// with fewer than min_neighbours set 8-connected neighbours, repeated for
// PASSES chained passes; pixels outside the frame and columns at or past
// row_width count as clear and read back as zero. Sustained rate is one row
// per cycle while results are popped and no flush holds the input: each pass
// computes all columns of a row at once from its two-row window. The last row
// of a frame of two or more rows stalls the input: each pass emits its flushed
// row while it holds its input, and a later pass's flush often lands on the
// bubble left by the first row of the next frame. A one-row frame goes
// straight through every pass with no flush. A frame of R rows gives
// exactly R result rows, the last one tagged frame_end; results trail
// inputs by one row per pass, plus the input queue and one output register
// per pass. The user must write configuration (row_width at index 0,
// min_neighbours at index 1) only when no request is in flight; not enforced.
module binary_neighbour_count_prune #(
    parameter int PASSES    = bncp_pkg::PASSES_DEF,
    parameter int MAX_WIDTH = bncp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [bncp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bncp_pkg::CFG_DATA_W-1:0] cfg_data,
    // input requests
    input  logic                            push,
    input  bncp_pkg::in_item_t              item,
    output logic                            full,
    // result requests
    output logic                            empty,
    input  logic                            pop,
    output bncp_pkg::out_item_t             result
);
    import bncp_pkg::*;

    logic                 q_wr, q_full, q_empty, q_rd;
    logic [MAX_WIDTH:0]   q_wdata, q_rdata;
    pass_ctrl_t           ctrl;
    logic [MAX_WIDTH-1:0] mask;
    logic                 back_ready;
    logic                 res_valid, res_last;
    logic [MAX_WIDTH-1:0] res_row;

    // front: config regs and masking of incoming rows
    bncp_front #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .push     (push),
        .item     (item),
        .q_full   (q_full),
        .q_wr     (q_wr),
        .q_data   (q_wdata),
        .ctrl     (ctrl),
        .mask     (mask)
    );

    // short queue decouples input acceptance from pass back-pressure
    bncp_fifo #(
        .WIDTH(MAX_WIDTH + 1),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_wr),
        .wr_data(q_wdata),
        .full   (q_full),
        .rd_en  (q_rd),
        .rd_data(q_rdata),
        .empty  (q_empty)
    );

    assign full = q_full;
    assign q_rd = back_ready && !q_empty;

    // back: chained passes; last pass's output register is the result slot
    bncp_back #(
        .PASSES   (PASSES),
        .MAX_WIDTH(MAX_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .mask     (mask),
        .in_valid (!q_empty),
        .in_ready (back_ready),
        .in_row   (q_rdata[MAX_WIDTH-1:0]),
        .in_last  (q_rdata[MAX_WIDTH]),
        .out_valid(res_valid),
        .out_ready(pop),
        .out_row  (res_row),
        .out_last (res_last)
    );

    assign empty             = !res_valid;
    assign result.pruned_row = ROW_W'(res_row);
    assign result.frame_end  = res_last;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the binary neighbour count pruning block.
`timescale 1ns / 1ps

module testbench;
    import bncp_pkg::*;

    // Stages of the design under test; it is built with its default pass count.
    localparam int STAGES       = PASSES_DEF;
    // Cycles allowed after the last expected row so queued requests settle.
    localparam int SETTLE_CYCLES = 40;
    // Upper bound on the whole run; far beyond the slowest legal run.
    localparam int CYCLE_LIMIT  = 200000;
    // Least number of rows per random phase; eight phases give the bulk of the stimulus.
    localparam int PHASE_ROWS   = 39;
    localparam int PHASE_COUNT  = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  push;
    in_item_t              item;
    logic                  full;
    logic                  empty;
    logic                  pop;
    out_item_t             result;

    binary_neighbour_count_prune dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // ------------------------------------------------------------------
    // Predictor state: a shadow of the register file and of the two-row
    // window that each pass keeps. held_rows counts rows in a stage (0..2).
    // ------------------------------------------------------------------
    logic [WIDTH_W-1:0] width_reg = ROW_WIDTH_RST;
    logic [MIN_W-1:0]   min_reg   = MIN_NB_RST;
    logic [ROW_W-1:0]   win_old   [STAGES];
    logic [ROW_W-1:0]   win_new   [STAGES];
    int                 held_rows [STAGES];

    // Rows the block still owes us, oldest first.
    out_item_t pending_rows[$];

    int  mismatches  = 0;
    int  cycles      = 0;
    // Idle bursts on the sending and receiving side are enabled per phase.
    bit  tx_idle_en  = 0;
    bit  rx_idle_en  = 0;

    // Columns at or past the row width are clear; widths above 64 act as 64.
    function automatic logic [ROW_W-1:0] row_mask();
        int w;
        w = int'(width_reg);
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        if (w >= ROW_W)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // One pass on the middle row: a set pixel survives only with at least
    // min_reg set neighbours among its eight; pixels off the frame are clear.
    function automatic logic [ROW_W-1:0] prune_line(input logic [ROW_W-1:0] above,
                                                    input logic [ROW_W-1:0] mid,
                                                    input logic [ROW_W-1:0] below);
        logic [ROW_W-1:0] m;
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] c;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] res;
        int               cnt;
        m   = row_mask();
        a   = above & m;
        c   = mid & m;
        b   = below & m;
        res = '0;
        for (int x = 0; x < ROW_W; x++)
        begin
            if (c[x])
            begin
                cnt = 0;
                for (int dx = -1; dx <= 1; dx++)
                begin
                    if (x + dx >= 0 && x + dx < ROW_W)
                    begin
                        cnt += int'(a[x + dx]) + int'(b[x + dx]);
                        if (dx != 0)
                            cnt += int'(c[x + dx]);
                    end
                end
                if (cnt >= int'(min_reg))
                    res[x] = 1'b1;
            end
        end
        return res & m;
    endfunction

    // Push one accepted row through the pass chain and queue the rows it
    // releases. A last row flushes each stage in turn with a clear row below.
    function automatic void predict_row(input logic [ROW_W-1:0] bits, input logic last);
        logic [ROW_W-1:0] cur[$];
        logic [ROW_W-1:0] nxt[$];
        out_item_t        exp_row;
        cur.insert(0, bits & row_mask());
        for (int s = 0; s < STAGES; s++)
        begin
            nxt.delete();
            foreach (cur[i])
            begin
                if (held_rows[s] == 0)
                begin
                    win_new[s]   = cur[i];
                    held_rows[s] = 1;
                end
                else
                begin
                    nxt.insert(nxt.size(),
                               prune_line(held_rows[s] == 2 ? win_old[s] : 64'd0,
                                          win_new[s], cur[i]));
                    win_old[s]   = win_new[s];
                    win_new[s]   = cur[i];
                    held_rows[s] = 2;
                end
            end
            if (last)
            begin
                if (held_rows[s] != 0)
                    nxt.insert(nxt.size(),
                               prune_line(held_rows[s] == 2 ? win_old[s] : 64'd0,
                                          win_new[s], 64'd0));
                win_old[s]   = '0;
                win_new[s]   = '0;
                held_rows[s] = 0;
            end
            cur = nxt;
        end
        foreach (cur[i])
        begin
            exp_row.pruned_row = cur[i];
            exp_row.frame_end  = last && (i == cur.size() - 1);
            pending_rows.insert(pending_rows.size(), exp_row);
        end
    endfunction

    function automatic void note_mismatch(input string what, input out_item_t exp_row,
                                          input out_item_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected row %h end %b, got row %h end %b", $realtime, what,
                     exp_row.pruned_row, exp_row.frame_end, got.pruned_row, got.frame_end);
    endfunction

    // Random row with a chosen density so that both isolated and crowded
    // pixels show up.
    function automatic logic [ROW_W-1:0] random_row();
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        r1 = {$urandom, $urandom};
        r2 = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            0, 1:    return r1;
            2, 3:    return r1 & r2;
            4:       return r1 | r2;
            5:       return r1 & r2 & {$urandom, $urandom};
            6:       return ($urandom_range(0, 1) != 0) ? '1 : '0;
            default: return 64'd1 << $urandom_range(0, ROW_W - 1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, cycle limit
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Result side: pop with random stall bursts, compare each accepted row
    // with the oldest expectation. Signals are read right after the edge,
    // before the design's updates land, so they are the values it saw.
    // ------------------------------------------------------------------
    initial
    begin
        int        stall;
        out_item_t exp_row;
        stall = 0;
        pop   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && pop && !empty)
            begin
                if (pending_rows.size() == 0)
                begin
                    exp_row = '0;
                    note_mismatch("unexpected result", exp_row, result);
                end
                else
                begin
                    exp_row = pending_rows.pop_front();
                    if (result.pruned_row !== exp_row.pruned_row
                        || result.frame_end !== exp_row.frame_end)
                        note_mismatch("result mismatch", exp_row, result);
                end
            end
            if (stall > 0)
            begin
                stall--;
                pop <= 1'b0;
            end
            else if (rst_n && rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 13) - 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= rst_n;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared tasks
    // ------------------------------------------------------------------

    // Offer one row and hold it until the block takes it. push stays high
    // afterwards so back-to-back requests follow without a gap.
    task automatic send_row(input logic [ROW_W-1:0] bits, input logic last);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{row_bits: bits, last_row: last};
        do
            @(posedge clk);
        while (full);
        predict_row(bits, last);
    endtask

    // Stop requesting, wait for every owed row, then give queued requests
    // time to finish before the registers may change.
    task automatic wait_idle();
        push <= 1'b0;
        while (pending_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; the shadow copy follows at the write edge.
    task automatic set_config(input logic [CFG_DATA_W-1:0] width_val,
                              input logic [CFG_DATA_W-1:0] min_val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ROW_WIDTH;
        cfg_data  <= width_val;
        @(posedge clk);
        width_reg = width_val[WIDTH_W-1:0];
        cfg_index <= CFG_MIN_NEIGHBOURS;
        cfg_data  <= min_val;
        @(posedge clk);
        min_reg = min_val[MIN_W-1:0];
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: full width, minimum of two neighbours. Covers crowded,
    // isolated and striped pixels, a one-row frame and an all-clear frame.
    task automatic test_reset_defaults();
        send_row('1, 1'b0);
        send_row(64'h0000_0001_0000_0000, 1'b0);
        send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        send_row('1, 1'b1);
        send_row('1, 1'b1);
        send_row('0, 1'b1);
        wait_idle();
    endtask

    // Row width at its limits: one column, none at all, and a setting past
    // the largest width, which acts as full width.
    task automatic test_width_extremes();
        set_config(7'd1, 7'd0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
        set_config(7'd0, 7'd0);
        send_row('1, 1'b1);
        wait_idle();
        set_config(7'h7F, 7'd3);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        wait_idle();
    endtask

    // Minimum of zero keeps the mask, eight keeps only fully surrounded
    // pixels, and anything above eight clears everything.
    task automatic test_min_extremes();
        set_config(7'd64, 7'd0);
        send_row({$urandom, $urandom}, 1'b0);
        send_row({$urandom, $urandom}, 1'b1);
        wait_idle();
        set_config(7'd64, 7'd8);
        send_row('1, 1'b0);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
        set_config(7'd40, 7'h7F);
        send_row('1, 1'b0);
        send_row('1, 1'b1);
        wait_idle();
    endtask

    // Register change while a frame is half way through: rows already held
    // are judged with the new setting from the next request on.
    task automatic test_mid_frame_write();
        set_config(7'd64, 7'd2);
        send_row(64'hFF00_FF00_0F0F_3C3C, 1'b0);
        send_row(64'h0FF0_0FF0_F0F0_C3C3, 1'b0);
        send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
        wait_idle();
        set_config(7'd20, 7'd4);
        send_row('1, 1'b0);
        send_row(64'h5555_5555_5555_5555, 1'b1);
        wait_idle();
    endtask

    // Random frames under a fresh setting per phase. The closing phase goes
    // back to the reset setting and runs with no idle cycles on either side.
    task automatic test_random_frames();
        int          rows;
        int          frame_len;
        logic [6:0]  width_val;
        logic [6:0]  min_val;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            if (phase == PHASE_COUNT - 1)
            begin
                width_val  = 7'd64;
                min_val    = 7'd2;
                tx_idle_en = 0;
                rx_idle_en = 0;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0:       width_val = 7'd64;
                    1:       width_val = 7'($urandom_range(1, 8));
                    2, 3:    width_val = 7'($urandom_range(9, 63));
                    4:       width_val = 7'($urandom_range(65, 127));
                    default: width_val = 7'($urandom_range(0, 2));
                endcase
                // upper bits of the data word are junk the block must ignore
                min_val = {3'($urandom), 4'($urandom_range(0, 8))};
                if ($urandom_range(0, 5) == 0)
                    min_val[3:0] = 4'($urandom_range(9, 15));
                tx_idle_en = $urandom_range(0, 3) != 0;
                rx_idle_en = $urandom_range(0, 3) != 0;
            end
            set_config(width_val, min_val);
            rows = 0;
            while (rows < PHASE_ROWS)
            begin
                frame_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                        : $urandom_range(1, 8);
                for (int r = 0; r < frame_len; r++)
                    send_row(random_row(), r == frame_len - 1);
                rows += frame_len;
            end
            wait_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ROW_WIDTH;
        cfg_data  = '0;
        push      = 1'b0;
        item      = '0;
        for (int s = 0; s < STAGES; s++)
        begin
            win_old[s]   = '0;
            win_new[s]   = '0;
            held_rows[s] = 0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_width_extremes();
        test_min_extremes();
        test_mid_frame_write();
        test_random_frames();

        wait_idle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
